// ===== rtl/windowed_minmax_autoscaler_macros.svh =====
// Assertion helpers for the windowed min/max autoscaler.
// Each macro needs clk and rst_n in scope at the point of use.
`ifndef WINDOWED_MINMAX_AUTOSCALER_MACROS_SVH
`define WINDOWED_MINMAX_AUTOSCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMAS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_minmax_autoscaler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WMAS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_minmax_autoscaler: next-cycle check failed");

`endif

// ===== rtl/wmas_pkg.sv =====
package wmas_pkg;

    // Store geometry.
    localparam int CHANNELS  = 8;
    localparam int DEPTH     = 1024;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int WIN_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = CH_W + IDX_W;
    localparam int MEM_DEPTH = CHANNELS << IDX_W;

    // Item field widths.
    localparam int CHANNEL_W = 3;
    localparam int SAMPLE_W  = 16;
    localparam int RANGE_W   = 17;

    // Configuration port.
    localparam int WINDOW_LENGTH_W   = 11;
    localparam int ACTIVE_CHANNELS_W = 4;
    localparam int CFG_DATA_W        = 11;
    localparam int CFG_IDX_W         = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 1'd1;

    localparam int MIN_WINDOW = 10;
    localparam logic [WINDOW_LENGTH_W-1:0]   WINDOW_RESET = 11'd100;
    localparam logic [ACTIVE_CHANNELS_W-1:0] ACTIVE_RESET = 4'd1;

    // Running extremes restart at the far ends of the sample range.
    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

    // Margin is span * 6554 / 65536, about one tenth of the span.
    localparam int MUL_W     = 13;
    localparam logic [MUL_W-1:0] MARGIN_MUL = 13'd6554;
    localparam int MARGIN_SH = 16;
    localparam int SPAN_W    = SAMPLE_W + 1;
    localparam int PROD_W    = SPAN_W + MUL_W;
    localparam int MARGIN_W  = PROD_W - MARGIN_SH;

    localparam int CLAMP_W = (WIN_W > WINDOW_LENGTH_W) ? WIN_W : WINDOW_LENGTH_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_MULT,
        ST_OUT
    } wmas_state_t;

    // Window length saturated to the legal range of the store.
    function automatic logic [WIN_W-1:0] clamp_window(input logic [WINDOW_LENGTH_W-1:0] v);
        logic [CLAMP_W-1:0] ext;
        ext = CLAMP_W'(v);
        if (ext < CLAMP_W'(MIN_WINDOW)) begin
            return WIN_W'(MIN_WINDOW);
        end
        if (ext > CLAMP_W'(DEPTH)) begin
            return WIN_W'(DEPTH);
        end
        return WIN_W'(ext);
    endfunction

    // Index of the last channel a rescan walks.
    function automatic logic [CH_W-1:0] last_active(input logic [ACTIVE_CHANNELS_W-1:0] v);
        if (v == '0) begin
            return '0;
        end
        if (int'(v) > CHANNELS) begin
            return CH_W'(CHANNELS - 1);
        end
        return CH_W'(v - 1'b1);
    endfunction

endpackage

// ===== rtl/wmas_if.sv =====
interface wmas_in_if;
    import wmas_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHANNEL_W-1:0]       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_set;

    modport source (output valid, output channel, output sample, output last_of_set,
                    input ready);
    modport sink (input valid, input channel, input sample, input last_of_set,
                  output ready);
endinterface

interface wmas_out_if;
    import wmas_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [RANGE_W-1:0] range_low;
    logic signed [RANGE_W-1:0] range_high;
    logic                      rescanned;

    modport source (output valid, output range_low, output range_high, output rescanned,
                    input ready);
    modport sink (input valid, input range_low, input range_high, input rescanned,
                  output ready);
endinterface

// ===== rtl/windowed_minmax_autoscaler.sv =====
// Windowed min/max autoscaler. Each accepted item writes one signed sample into its
// channel's ring (window_length entries per channel) and keeps a running minimum and
// maximum; an item with last_of_set high yields one result holding the range widened by
// roughly a tenth of its span on each side. An item without a result passes through the
// update step only, and one with a result also through the multiply and output steps,
// all on one sequencer that owns the single read port of the sample memory. When the
// overwritten entry was the current minimum or maximum, the result first walks every
// active channel's window through that same read port, one entry per cycle.
// The input is not ready while an item is being worked on. The result sits in an output
// register, so the next item is taken while a result still waits; only the final step of
// a later result stalls until the earlier one is taken. There is no clearing pass: each
// ring keeps a fill mark, so entries that have not been written since reset or since the
// last window length change read as zero. Configuration should be written only while the
// block is idle; a change of the effective window length empties every ring.
`include "windowed_minmax_autoscaler_macros.svh"

module windowed_minmax_autoscaler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [wmas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wmas_pkg::CFG_DATA_W-1:0] cfg_wdata,
    wmas_in_if.sink                         in_item,
    wmas_out_if.source                      out_item
);
    import wmas_pkg::*;

    // Sample memory: one write port and one registered read port.
    logic [SAMPLE_W-1:0] mem [0:MEM_DEPTH-1];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;

    // Configuration.
    logic [WIN_W-1:0]             win_reg;
    logic [ACTIVE_CHANNELS_W-1:0] active_reg;
    logic [WIN_W-1:0]             win_clamped;
    logic                         win_chg;

    // Ring heads and fill marks. A ring that has wrapped is full; before that,
    // only entries below the head have been written.
    logic [IDX_W-1:0]    head_reg [CHANNELS];
    logic [CHANNELS-1:0] full_reg;
    logic                head_wr;
    logic [IDX_W-1:0]    head_wr_val;
    logic                full_set;

    // Sequencer.
    wmas_state_t state_reg, state_next;

    // The item being worked on.
    logic [CH_W-1:0]            ch_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       last_reg;
    logic                       chan_ok_reg;
    logic [IDX_W-1:0]           head_cur_reg;

    // Running extremes and rescan flags.
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic                       pending_reg, pending_next;
    logic                       scanned_reg, scanned_next;

    // Rescan walker; the compare runs in the cycle after its address is issued.
    logic [CH_W-1:0]  scan_ch_reg, scan_ch_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             scan_ok_reg, scan_ok_next;
    logic             scan_cmp_reg, scan_cmp_next;

    // Margin multiply and result register.
    logic [PROD_W-1:0]         prod_reg;
    logic [SPAN_W-1:0]         span;
    logic [MARGIN_W-1:0]       margin;
    logic                      out_valid_reg, out_valid_next;
    logic signed [RANGE_W-1:0] range_low_reg, range_high_reg;
    logic                      rescanned_reg;
    logic                      out_load;

    // Combinational helpers.
    logic                       in_fire;
    logic                       in_ok;
    logic [CH_W-1:0]            in_ch;
    logic [IDX_W-1:0]           in_head;
    logic signed [SAMPLE_W-1:0] old_val;
    logic                       old_hit;
    logic [WIN_W-1:0]           head_inc;
    logic signed [SAMPLE_W-1:0] scan_val;
    logic [CH_W-1:0]            last_ch;
    logic                       idx_at_end;

    assign in_item.ready    = (state_reg == ST_IDLE);
    assign in_fire          = in_item.valid && in_item.ready;
    assign out_item.valid      = out_valid_reg;
    assign out_item.range_low  = range_low_reg;
    assign out_item.range_high = range_high_reg;
    assign out_item.rescanned  = rescanned_reg;

    assign in_ok   = (int'(in_item.channel) < CHANNELS);
    assign in_ch   = CH_W'(in_item.channel);
    // A head at or beyond the window end restarts at zero.
    assign in_head = (WIN_W'(head_reg[in_ch]) >= win_reg) ? '0 : head_reg[in_ch];

    assign win_clamped = clamp_window(cfg_wdata[WINDOW_LENGTH_W-1:0]);
    assign win_chg     = cfg_wr_en && (cfg_index == CFG_WINDOW_LENGTH) &&
                         (win_clamped != win_reg);

    // Entries never written since the ring was emptied read as zero.
    assign old_val  = full_reg[ch_reg] ? $signed(rd_data_reg) : '0;
    assign old_hit  = (old_val == min_reg) || (old_val == max_reg);
    assign head_inc = WIN_W'(head_cur_reg) + WIN_W'(1);
    assign scan_val = scan_ok_reg ? $signed(rd_data_reg) : '0;
    assign last_ch  = last_active(active_reg);
    assign idx_at_end = (WIN_W'(scan_idx_reg) == (win_reg - WIN_W'(1)));

    assign span   = (max_reg >= min_reg)
                  ? SPAN_W'({max_reg[SAMPLE_W-1], max_reg} - {min_reg[SAMPLE_W-1], min_reg})
                  : '0;
    assign margin = prod_reg[PROD_W-1:MARGIN_SH];

    assign wr_addr = {ch_reg, head_cur_reg};

    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        pending_next   = pending_reg;
        scanned_next   = scanned_reg;
        scan_ch_next   = scan_ch_reg;
        scan_idx_next  = scan_idx_reg;
        scan_ok_next   = 1'b0;
        scan_cmp_next  = 1'b0;
        rd_addr        = {scan_ch_reg, scan_idx_reg};
        mem_we         = 1'b0;
        head_wr        = 1'b0;
        head_wr_val    = '0;
        full_set       = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_item.ready;

        // The rescan compare finishes the read issued in the previous cycle.
        if (scan_cmp_reg) begin
            if (scan_val < min_reg) begin
                min_next = scan_val;
            end
            if (scan_val > max_reg) begin
                max_next = scan_val;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Fetch the entry about to be overwritten.
                rd_addr = {in_ch, in_head};
                if (in_fire) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (chan_ok_reg) begin
                    pending_next = pending_reg || old_hit;
                    mem_we       = 1'b1;
                    head_wr      = 1'b1;
                    if (head_inc >= win_reg) begin
                        head_wr_val = '0;
                        full_set    = 1'b1;
                    end
                    else begin
                        head_wr_val = IDX_W'(head_inc);
                    end
                    if (!pending_next) begin
                        if (samp_reg < min_reg) begin
                            min_next = samp_reg;
                        end
                        if (samp_reg > max_reg) begin
                            max_next = samp_reg;
                        end
                    end
                end
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end
                else if (pending_next) begin
                    state_next    = ST_SCAN;
                    min_next      = MIN_RESET;
                    max_next      = MAX_RESET;
                    pending_next  = 1'b0;
                    scanned_next  = 1'b1;
                    scan_ch_next  = '0;
                    scan_idx_next = '0;
                end
                else begin
                    state_next   = ST_MULT;
                    scanned_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                scan_ok_next  = full_reg[scan_ch_reg] || (scan_idx_reg < head_reg[scan_ch_reg]);
                scan_cmp_next = 1'b1;
                if (idx_at_end) begin
                    scan_idx_next = '0;
                    if (scan_ch_reg == last_ch) begin
                        state_next = ST_SCAN_TAIL;
                    end
                    else begin
                        scan_ch_next = scan_ch_reg + CH_W'(1);
                    end
                end
                else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_SCAN_TAIL:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Wait here while an earlier result has not been taken.
                if (!out_valid_reg || out_item.ready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            pending_reg   <= 1'b0;
            scanned_reg   <= 1'b0;
            scan_ch_reg   <= '0;
            scan_idx_reg  <= '0;
            scan_ok_reg   <= 1'b0;
            scan_cmp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            pending_reg   <= pending_next;
            scanned_reg   <= scanned_next;
            scan_ch_reg   <= scan_ch_next;
            scan_idx_reg  <= scan_idx_next;
            scan_ok_reg   <= scan_ok_next;
            scan_cmp_reg  <= scan_cmp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers, ring heads and fill marks. A window change wins over a
    // head update so that the rings are always left empty after it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_reg    <= clamp_window(WINDOW_RESET);
            active_reg <= ACTIVE_RESET;
            full_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                head_reg[c] <= '0;
            end
        end
        else begin
            if (cfg_wr_en && (cfg_index == CFG_ACTIVE_CHANNELS)) begin
                active_reg <= cfg_wdata[ACTIVE_CHANNELS_W-1:0];
            end
            if (win_chg) begin
                win_reg  <= win_clamped;
                full_reg <= '0;
                for (int c = 0; c < CHANNELS; c++) begin
                    head_reg[c] <= '0;
                end
            end
            else if (head_wr) begin
                head_reg[ch_reg] <= head_wr_val;
                if (full_set) begin
                    full_reg[ch_reg] <= 1'b1;
                end
            end
        end
    end

    // Item capture, margin product and result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            ch_reg       <= in_ch;
            samp_reg     <= in_item.sample;
            last_reg     <= in_item.last_of_set;
            chan_ok_reg  <= in_ok;
            head_cur_reg <= in_head;
        end
        if (state_reg == ST_MULT) begin
            prod_reg <= PROD_W'(span) * PROD_W'(MARGIN_MUL);
        end
        if (out_load) begin
            range_low_reg  <= RANGE_W'(min_reg) - RANGE_W'(margin);
            range_high_reg <= RANGE_W'(max_reg) + RANGE_W'(margin);
            rescanned_reg  <= scanned_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[wr_addr] <= samp_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // A rescan holds off new items for its whole walk.
    `WMAS_ASSERT_IMP(a_scan_holds_input, (state_reg == ST_SCAN) || (state_reg == ST_SCAN_TAIL), !in_item.ready)
    // The ring head of channel 0 always stays inside the current window.
    `WMAS_ASSERT_IMP(a_head_in_window, 1'b1, WIN_W'(head_reg[0]) < win_reg)
    // A window length change clears every fill mark and the head of channel 0.
    `WMAS_ASSERT_NXT(a_win_change_empties, win_chg, (full_reg == '0) && (head_reg[0] == '0))
    // A new result never leaves a rescan owed.
    `WMAS_ASSERT_IMP(a_result_clears_pending, $rose(out_valid_reg), !pending_reg)

endmodule

// ===== tb/sv/tb_windowed_minmax_autoscaler.sv =====
`timescale 1ns / 100ps

module tb_windowed_minmax_autoscaler;
    import wmas_pkg::*;

    // Quiet cycles allowed before the run is declared hung. The slowest step is a
    // rescan of eight full windows, and this leaves ample room for it.
    localparam int WATCHDOG_LIMIT   = 50000;
    // Cycles left after the last expected result so trailing items can finish.
    localparam int SETTLE_CYCLES    = 16;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES      = 400;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int HEAVY_IDLE_PCT   = 79;
    localparam int LIGHT_IDLE_PCT   = 8;
    localparam int MARGIN_FACTOR    = 6554;
    localparam int SAMPLE_TOP       = 32767;
    localparam int SAMPLE_BOTTOM    = -32768;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]       channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_set;
    } sample_item_t;

    typedef struct packed {
        logic signed [RANGE_W-1:0] range_low;
        logic signed [RANGE_W-1:0] range_high;
        logic                      rescanned;
    } range_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    wmas_in_if  in_bus ();
    wmas_out_if out_bus ();

    windowed_minmax_autoscaler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_bus),
        .out_item  (out_bus)
    );

    // Items waiting to be offered, and ranges the block owes us, oldest first.
    sample_item_t pending_samples[$];
    range_item_t  expected_ranges[$];

    idle_mode_t idle_mode;
    bit         pressure_on;
    bit         pressure_done;
    int         hold_left;
    int         mismatch_count;
    int         quiet_cycles;

    // Our own copy of the block's state: the sample history of every ring, the
    // write position of each ring, the running extremes and the rescan flag.
    logic signed [SAMPLE_W-1:0]   hist [CHANNELS][DEPTH];
    int unsigned                  ring_pos [CHANNELS];
    int                           lo_run;
    int                           hi_run;
    bit                           scan_due;
    int unsigned                  win_used;
    logic [ACTIVE_CHANNELS_W-1:0] chan_reg;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The window length in use is the register saturated to the minimum window and the size of the store.
    function automatic int unsigned saturate_window(input logic [WINDOW_LENGTH_W-1:0] v);
        if (v < MIN_WINDOW)
        begin
            return MIN_WINDOW;
        end
        if (v > DEPTH)
        begin
            return DEPTH;
        end
        return v;
    endfunction

    // Number of channels a rescan walks; zero and overlarge values saturate.
    function automatic int unsigned walked_channels();
        if (chan_reg == '0)
        begin
            return 1;
        end
        if (chan_reg > CHANNELS)
        begin
            return CHANNELS;
        end
        return chan_reg;
    endfunction

    function automatic void clear_history();
        for (int c = 0; c < CHANNELS; c++)
        begin
            ring_pos[c] = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                hist[c][i] = '0;
            end
        end
    endfunction

    // Full walk of the first win_used entries of every active ring.
    function automatic void rescan_windows();
        int v;
        lo_run = SAMPLE_TOP;
        hi_run = SAMPLE_BOTTOM;
        for (int c = 0; c < walked_channels(); c++)
        begin
            for (int i = 0; i < win_used; i++)
            begin
                v = hist[c][i];
                if (v < lo_run)
                begin
                    lo_run = v;
                end
                if (v > hi_run)
                begin
                    hi_run = v;
                end
            end
        end
    endfunction

    // Applies one accepted item to the shadow state and, on the final item of a
    // set, queues the widened range the block must return for it.
    function automatic void take_sample(input sample_item_t it);
        int unsigned pos;
        int          prev;
        int          s;
        longint      span;
        longint      margin;
        range_item_t r;
        s = it.sample;
        if (it.channel < CHANNELS)
        begin
            pos = ring_pos[it.channel];
            if (pos >= win_used)
            begin
                pos = 0;
            end
            // Overwriting a value that is one of the extremes makes them stale.
            prev = hist[it.channel][pos];
            if (prev == lo_run || prev == hi_run)
            begin
                scan_due = 1'b1;
            end
            hist[it.channel][pos] = it.sample;
            pos++;
            if (pos >= win_used)
            begin
                pos = 0;
            end
            ring_pos[it.channel] = pos;
            if (!scan_due)
            begin
                if (s < lo_run)
                begin
                    lo_run = s;
                end
                if (s > hi_run)
                begin
                    hi_run = s;
                end
            end
        end
        if (it.last_of_set)
        begin
            r.rescanned = scan_due;
            if (scan_due)
            begin
                rescan_windows();
                scan_due = 1'b0;
            end
            span   = (hi_run >= lo_run) ? longint'(hi_run - lo_run) : 0;
            margin = (span * MARGIN_FACTOR) >>> 16;
            r.range_low  = RANGE_W'(lo_run - margin);
            r.range_high = RANGE_W'(hi_run + margin);
            expected_ranges.push_back(r);
        end
    endfunction

    // Random item: mostly on active channels, with samples drawn often from the
    // extremes and a tight cluster so that overwrites hit the running min or max.
    function automatic sample_item_t make_sample(input bit last);
        sample_item_t it;
        int           pick;
        if ($urandom_range(99) < 80)
        begin
            it.channel = CHANNEL_W'($urandom_range(walked_channels() - 1));
        end
        else
        begin
            it.channel = CHANNEL_W'($urandom_range((1 << CHANNEL_W) - 1));
        end
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            it.sample = SAMPLE_W'(SAMPLE_TOP);
        end
        else if (pick < 20)
        begin
            it.sample = SAMPLE_W'(SAMPLE_BOTTOM);
        end
        else if (pick < 45)
        begin
            it.sample = SAMPLE_W'(int'($urandom_range(6)) - 3);
        end
        else
        begin
            it.sample = SAMPLE_W'($urandom_range(16'hffff));
        end
        it.last_of_set = last;
        return it;
    endfunction

    task automatic push_sample(input int ch, input int s, input bit last);
        sample_item_t it;
        it.channel     = CHANNEL_W'(ch);
        it.sample      = SAMPLE_W'(s);
        it.last_of_set = last;
        pending_samples.push_back(it);
    endtask

    // Most of the stimulus is whole sets ending in a final item; the rest is
    // stray single items and sets that are cut off before their final item.
    task automatic queue_random_sets(input int count);
        int added;
        int len;
        int kind;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                pending_samples.push_back(make_sample(1'b0));
                added++;
            end
            else if (kind < 18)
            begin
                len = $urandom_range(4, 1);
                repeat (len) pending_samples.push_back(make_sample(1'b0));
                added += len;
            end
            else
            begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                begin
                    pending_samples.push_back(make_sample(k == len - 1));
                end
                added += len;
            end
        end
    endtask

    // Registers are written only once the block has gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        int unsigned next_win;
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH)
        begin
            // Only a change of the length in use empties the rings.
            next_win = saturate_window(value[WINDOW_LENGTH_W-1:0]);
            if (next_win != win_used)
            begin
                win_used = next_win;
                clear_history();
            end
        end
        else if (idx == CFG_ACTIVE_CHANNELS)
        begin
            chan_reg = value[ACTIVE_CHANNELS_W-1:0];
        end
    endtask

    // Waits until every item is taken and every expected range has come back,
    // then gives a trailing item without a result time to finish.
    task automatic drain();
        while (pending_samples.size() != 0 || in_bus.valid || expected_ranges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] act,
                             input idle_mode_t mode, input int count, input bit squeeze);
        drain();
        write_reg(CFG_WINDOW_LENGTH, win);
        write_reg(CFG_ACTIVE_CHANNELS, act);
        @(negedge clk);
        idle_mode   <= mode;
        pressure_on <= squeeze;
        queue_random_sets(count);
    endtask

    // Sender: offers queued items, holding each until the block takes it.
    always @(posedge clk)
    begin : feed_samples
        sample_item_t got;
        sample_item_t next_item;
        bit           pause;
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
            begin
                got.channel     = in_bus.channel;
                got.sample      = in_bus.sample;
                got.last_of_set = in_bus.last_of_set;
                take_sample(got);
            end
            if (!in_bus.valid || in_bus.ready)
            begin
                pause = (idle_mode == IDLE_SEND && $urandom_range(99) < HEAVY_IDLE_PCT)
                     || (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_IDLE_PCT);
                if (pending_samples.size() != 0 && !pause)
                begin
                    next_item = pending_samples.pop_front();
                    in_bus.valid       <= 1'b1;
                    in_bus.channel     <= next_item.channel;
                    in_bus.sample      <= next_item.sample;
                    in_bus.last_of_set <= next_item.last_of_set;
                end
                else
                begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each taken range against the oldest expectation and
    // drives ready, including the one long hold-off of the pressure phase.
    always @(posedge clk)
    begin : check_ranges
        range_item_t want;
        bit          stall;
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_ranges.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                    begin
                        $display("unexpected range at %0t: low %0d high %0d rescanned %0b",
                                 $time, out_bus.range_low, out_bus.range_high,
                                 out_bus.rescanned);
                    end
                end
                else
                begin
                    want = expected_ranges.pop_front();
                    if (out_bus.range_low !== want.range_low
                        || out_bus.range_high !== want.range_high
                        || out_bus.rescanned !== want.rescanned)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_MISMATCHES)
                        begin
                            $display("range mismatch at %0t: expected low %0d high %0d rescanned %0b",
                                     $time, want.range_low, want.range_high, want.rescanned);
                            $display("    got low %0d high %0d rescanned %0b",
                                     out_bus.range_low, out_bus.range_high,
                                     out_bus.rescanned);
                        end
                    end
                end
            end
            if (pressure_on && !pressure_done)
            begin
                hold_left     <= HOLD_CYCLES;
                pressure_done <= 1'b1;
                out_bus.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                stall = (idle_mode == IDLE_RECV && $urandom_range(99) < HEAVY_IDLE_PCT)
                     || (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_IDLE_PCT);
                out_bus.ready <= !stall;
            end
        end
    end

    // Watchdog: any cycle in which an item moves on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_WINDOW_LENGTH;
        cfg_wdata          = '0;
        in_bus.valid       = 1'b0;
        in_bus.channel     = '0;
        in_bus.sample      = '0;
        in_bus.last_of_set = 1'b0;
        out_bus.ready      = 1'b0;
        idle_mode          = IDLE_NONE;
        pressure_on        = 1'b0;
        pressure_done      = 1'b0;
        hold_left          = 0;
        mismatch_count     = 0;
        quiet_cycles       = 0;

        win_used = saturate_window(WINDOW_RESET);
        chan_reg = ACTIVE_RESET;
        lo_run   = SAMPLE_TOP;
        hi_run   = SAMPLE_BOTTOM;
        scan_due = 1'b0;
        clear_history();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: the sample extremes, a full-scale span that gives the
        // widest possible range, items with no result and an inactive channel.
        push_sample(0, SAMPLE_TOP, 1'b1);
        push_sample(0, SAMPLE_BOTTOM, 1'b1);
        push_sample(7, 0, 1'b0);
        push_sample(3, -1, 1'b0);
        push_sample(5, 1, 1'b1);
        push_sample(2, 12345, 1'b1);
        drain();

        // A window length of zero saturates to the minimum and empties the rings;
        // zero active channels count as one. The eleventh item on channel 0 wraps
        // and overwrites the maximum, so its set comes from a rescan. The item on
        // channel 1 lands in an inactive ring but still moves the running maximum.
        write_reg(CFG_WINDOW_LENGTH, '0);
        write_reg(CFG_ACTIVE_CHANNELS, '0);
        @(negedge clk);
        push_sample(0, SAMPLE_TOP, 1'b0);
        push_sample(0, -100, 1'b0);
        push_sample(0, 7, 1'b0);
        push_sample(0, 7, 1'b0);
        push_sample(0, -3, 1'b1);
        push_sample(0, 0, 1'b0);
        push_sample(0, 2, 1'b0);
        push_sample(0, 2, 1'b0);
        push_sample(0, 1, 1'b0);
        push_sample(0, 50, 1'b1);
        push_sample(0, 8, 1'b1);
        push_sample(1, 30000, 1'b1);
        drain();

        // A length below the minimum maps to the same length in use, so the rings
        // are kept; fifteen active channels saturate to all of them, and the next
        // overwrite of the minimum makes the rescan pick up the inactive ring too.
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(5));
        write_reg(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(15));
        @(negedge clk);
        push_sample(0, SAMPLE_BOTTOM, 1'b0);
        push_sample(4, SAMPLE_TOP, 1'b1);
        push_sample(0, 9, 1'b1);

        // Random phases. Long windows make rescans slow, so they get few items;
        // short windows wrap often and take most of the stimulus.
        run_phase(CFG_DATA_W'(2047), CFG_DATA_W'(15), IDLE_NONE, 40, 1'b0);
        run_phase(CFG_DATA_W'(12), CFG_DATA_W'(3), IDLE_SEND, 70, 1'b0);
        run_phase(CFG_DATA_W'(16), CFG_DATA_W'(8), IDLE_RECV, 70, 1'b0);
        run_phase(CFG_DATA_W'(10), CFG_DATA_W'(2), IDLE_BOTH, 60, 1'b0);
        run_phase(CFG_DATA_W'(25), CFG_DATA_W'(4), IDLE_NONE, 60, 1'b1);
        run_phase(CFG_DATA_W'(1024), CFG_DATA_W'(1), IDLE_SEND, 30, 1'b0);
        run_phase(CFG_DATA_W'(11), CFG_DATA_W'(8), IDLE_BOTH, 70, 1'b0);
        drain();

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wmas_pkg.sv
rtl/wmas_if.sv
rtl/windowed_minmax_autoscaler.sv
tb/sv/tb_windowed_minmax_autoscaler.sv
